// ===== src/sha256_sha224_hash_core_unit_assert.svh =====
// ----------------------------------------------------------------------------
// sha256_sha224_hash_core_unit_assert.svh
// Assertion macros used by the hash core engine (sha_core)
// ----------------------------------------------------------------------------
`ifndef SHA256_SHA224_HASH_CORE_UNIT_ASSERT_SVH
`define SHA256_SHA224_HASH_CORE_UNIT_ASSERT_SVH

// same-cycle implication, checked outside reset
`define SHA_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define SHA_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/sha_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha_pkg
// Types, constants and round functions of the SHA-256/SHA-224 hash core
// ----------------------------------------------------------------------------
package sha_pkg;

    localparam int ROUNDS    = 64;
    localparam int RND_W     = 6;
    localparam int WORDS     = 8;
    localparam int BLK_WORDS = 16;
    localparam int POS_W     = 4;

    // front queue between word intake and the compression engine
    localparam int FQ_DEPTH = 16;
    localparam int FQ_AW    = 4;

    // digest queue on the result side
    localparam int OQ_DEPTH = 8;
    localparam int OQ_AW    = 3;

    localparam logic MODE_SHA256 = 1'b0;
    localparam logic MODE_SHA224 = 1'b1;

    localparam logic [2:0] LAST_IDX_256 = 3'd7;
    localparam logic [2:0] LAST_IDX_224 = 3'd6;

    localparam logic [31:0] IV256 [WORDS] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] IV224 [WORDS] = '{
        32'hc1059ed8, 32'h367cd507, 32'h3070dd17, 32'hf70e5939,
        32'hffc00b31, 32'h68581511, 32'h64f98fa7, 32'hbefa4fa4
    };

    localparam logic [31:0] ROUND_K [ROUNDS] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    // one classified message word
    typedef struct packed {
        logic [31:0] word;
        logic        msg_end;
        logic        blk_last;
    } sha_item_t;

    // one digest word
    typedef struct packed {
        logic [31:0] word;
        logic        last;
    } sha_dig_t;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_ROUND,
        ST_FINAL,
        ST_EMIT
    } sha_state_t;

    function automatic logic [31:0] iv_word(input logic mode, input logic [2:0] idx);
        iv_word = (mode == MODE_SHA224) ? IV224[idx] : IV256[idx];
    endfunction

    function automatic logic [31:0] bsig0(input logic [31:0] v);
        bsig0 = {v[1:0], v[31:2]} ^ {v[12:0], v[31:13]} ^ {v[21:0], v[31:22]};
    endfunction

    function automatic logic [31:0] bsig1(input logic [31:0] v);
        bsig1 = {v[5:0], v[31:6]} ^ {v[10:0], v[31:11]} ^ {v[24:0], v[31:25]};
    endfunction

    function automatic logic [31:0] ssig0(input logic [31:0] v);
        ssig0 = {v[6:0], v[31:7]} ^ {v[17:0], v[31:18]} ^ {3'b000, v[31:3]};
    endfunction

    function automatic logic [31:0] ssig1(input logic [31:0] v);
        ssig1 = {v[16:0], v[31:17]} ^ {v[18:0], v[31:19]} ^ {10'b0, v[31:10]};
    endfunction

endpackage

// ===== src/sha256_sha224_hash_core_unit.sv =====
`timescale 1ns / 1ps
// Usage:
//   Message words of an already padded message enter through push/full, sixteen
//   per 512-bit block, with message_end high on the final word. A word is taken
//   at a clock edge with push high and full low. Digest words leave through
//   empty/pop, first word first; digest_last marks the eighth word (SHA-256) or
//   the seventh (SHA-224). The cfg channel writes digest_mode (0 SHA-256,
//   1 SHA-224) while the unit is idle; cfg_ready is always high and a write
//   reloads the initial hash values and restarts the block position.
//   A block is loaded word by word, then runs 64 rounds and one feed-forward
//   step, all on the single round unit. A 16-word queue in front keeps taking
//   words while rounds run. A final word that closes a block is followed by
//   the rounds and the feed-forward before the first digest word, and the
//   digest words follow one per cycle while the digest queue is not full.
//   Reset leaves SHA-256 selected, both queues empty, no request pending.
//   A stalled receiver fills the 8-word digest queue; the engine then waits
//   and the input queue backs up until full rises.
// ----------------------------------------------------------------------------
// sha256_sha224_hash_core_unit
// SHA-256/SHA-224 hash core top level
// ----------------------------------------------------------------------------
module sha256_sha224_hash_core_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [31:0] message_word,
    input  logic        message_end,
    output logic        empty,
    input  logic        pop,
    output logic [31:0] digest_word,
    output logic        digest_last,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_data
);

    logic                q_valid;
    logic                q_pop;
    sha_pkg::sha_item_t  q_item;
    logic                d_push;
    logic                d_full;
    sha_pkg::sha_dig_t   d_item;
    logic                cfg_write;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    // word intake and tagging
    sha_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .message_word (message_word),
        .message_end  (message_end),
        .cfg_write    (cfg_write),
        .q_valid      (q_valid),
        .q_item       (q_item),
        .q_pop        (q_pop)
    );

    // compression engine
    sha_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_mode  (cfg_data),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop),
        .d_push    (d_push),
        .d_item    (d_item),
        .d_full    (d_full)
    );

    // digest queue
    sha_out u_out (
        .clk         (clk),
        .rst_n       (rst_n),
        .d_push      (d_push),
        .d_item      (d_item),
        .d_full      (d_full),
        .empty       (empty),
        .pop         (pop),
        .digest_word (digest_word),
        .digest_last (digest_last)
    );

endmodule

// ===== src/sha_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha_front
// Word intake: tracks position in the block, tags words, queues them
// ----------------------------------------------------------------------------
module sha_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  logic [31:0]         message_word,
    input  logic                message_end,
    input  logic                cfg_write,
    output logic                q_valid,
    output sha_pkg::sha_item_t  q_item,
    input  logic                q_pop
);

    sha_pkg::sha_item_t             mem_reg [sha_pkg::FQ_DEPTH];
    logic [sha_pkg::FQ_AW-1:0]      wr_ptr_reg;
    logic [sha_pkg::FQ_AW-1:0]      wr_ptr_next;
    logic [sha_pkg::FQ_AW-1:0]      rd_ptr_reg;
    logic [sha_pkg::FQ_AW-1:0]      rd_ptr_next;
    logic [sha_pkg::FQ_AW:0]        cnt_reg;
    logic [sha_pkg::FQ_AW:0]        cnt_next;
    logic [sha_pkg::POS_W-1:0]      pos_reg;
    logic [sha_pkg::POS_W-1:0]      pos_next;
    logic                           in_req;
    logic                           out_req;
    sha_pkg::sha_item_t             new_item;

    assign full    = (cnt_reg == (sha_pkg::FQ_AW + 1)'(sha_pkg::FQ_DEPTH));
    assign q_valid = (cnt_reg != '0);
    assign q_item  = mem_reg[rd_ptr_reg];
    assign in_req  = push && !full;
    assign out_req = q_pop && q_valid;

    // tag the incoming word
    always_comb
    begin
        new_item.word     = message_word;
        new_item.msg_end  = message_end;
        new_item.blk_last = (pos_reg == (sha_pkg::POS_W)'(sha_pkg::BLK_WORDS - 1));
    end

    // block position and queue pointers
    always_comb
    begin
        pos_next    = pos_reg;
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (in_req)
        begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
            if (message_end || new_item.blk_last)
            begin
                pos_next = '0;
            end
            else
            begin
                pos_next = pos_reg + 1'b1;
            end
        end
        if (out_req)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (in_req && !out_req)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (out_req && !in_req)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
        if (cfg_write)
        begin
            pos_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            pos_reg    <= pos_next;
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (in_req)
        begin
            mem_reg[wr_ptr_reg] <= new_item;
        end
    end

endmodule

// ===== src/sha_out.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha_out
// Digest word queue toward the result side
// ----------------------------------------------------------------------------
module sha_out (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               d_push,
    input  sha_pkg::sha_dig_t  d_item,
    output logic               d_full,
    output logic               empty,
    input  logic               pop,
    output logic [31:0]        digest_word,
    output logic               digest_last
);

    sha_pkg::sha_dig_t           mem_reg [sha_pkg::OQ_DEPTH];
    logic [sha_pkg::OQ_AW-1:0]   wr_ptr_reg;
    logic [sha_pkg::OQ_AW-1:0]   rd_ptr_reg;
    logic [sha_pkg::OQ_AW:0]     cnt_reg;
    logic [sha_pkg::OQ_AW:0]     cnt_next;
    logic                        in_req;
    logic                        out_req;
    sha_pkg::sha_dig_t           head;

    assign d_full      = (cnt_reg == (sha_pkg::OQ_AW + 1)'(sha_pkg::OQ_DEPTH));
    assign empty       = (cnt_reg == '0);
    assign in_req      = d_push && !d_full;
    assign out_req     = pop && !empty;
    assign head        = mem_reg[rd_ptr_reg];
    assign digest_word = head.word;
    assign digest_last = head.last;

    // occupancy
    always_comb
    begin
        cnt_next = cnt_reg;
        if (in_req && !out_req)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (out_req && !in_req)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (in_req)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (out_req)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            cnt_reg <= cnt_next;
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (in_req)
        begin
            mem_reg[wr_ptr_reg] <= d_item;
        end
    end

endmodule

// ===== src/sha_core.sv =====
`timescale 1ns / 1ps
`include "sha256_sha224_hash_core_unit_assert.svh"
// ----------------------------------------------------------------------------
// sha_core
// Compression engine: loads the schedule window, runs 64 rounds, emits digest
// ----------------------------------------------------------------------------
module sha_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_write,
    input  logic                cfg_mode,
    input  logic                q_valid,
    input  sha_pkg::sha_item_t  q_item,
    output logic                q_pop,
    output logic                d_push,
    output sha_pkg::sha_dig_t   d_item,
    input  logic                d_full
);

    sha_pkg::sha_state_t        state_reg;
    sha_pkg::sha_state_t        state_next;
    logic                       mode_reg;
    logic                       pend_end_reg;
    logic                       pend_end_next;
    logic [sha_pkg::RND_W-1:0]  rnd_reg;
    logic [2:0]                 idx_reg;
    logic [31:0]                chain_reg [sha_pkg::WORDS];
    logic [31:0]                v_reg [sha_pkg::WORDS];
    logic [31:0]                w_reg [sha_pkg::BLK_WORDS];

    logic                       shift_en;
    logic [31:0]                shift_in;
    logic [31:0]                w_new;
    logic [31:0]                t1;
    logic [31:0]                t2;
    logic [31:0]                ch;
    logic [31:0]                maj;
    logic [2:0]                 last_idx;
    logic                       rnd_last;
    logic                       emit_last;
    logic                       load_blk;

    // round datapath
    always_comb
    begin
        w_new = sha_pkg::ssig1(w_reg[14]) + w_reg[9] + sha_pkg::ssig0(w_reg[1]) + w_reg[0];
        ch    = (v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]);
        maj   = (v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
        t1    = v_reg[7] + sha_pkg::bsig1(v_reg[4]) + ch + sha_pkg::ROUND_K[rnd_reg]
              + w_reg[0];
        t2    = sha_pkg::bsig0(v_reg[0]) + maj;
    end

    assign last_idx  = (mode_reg == sha_pkg::MODE_SHA224) ? sha_pkg::LAST_IDX_224
                                                          : sha_pkg::LAST_IDX_256;
    assign rnd_last  = (rnd_reg == (sha_pkg::RND_W)'(sha_pkg::ROUNDS - 1));
    assign emit_last = (idx_reg == last_idx);

    // next state
    always_comb
    begin
        state_next    = state_reg;
        pend_end_next = pend_end_reg;
        case (state_reg)
            sha_pkg::ST_LOAD:
            begin
                if (q_valid)
                begin
                    pend_end_next = q_item.msg_end;
                    if (q_item.blk_last)
                    begin
                        state_next = sha_pkg::ST_ROUND;
                    end
                    else if (q_item.msg_end)
                    begin
                        state_next = sha_pkg::ST_EMIT;
                    end
                end
            end
            sha_pkg::ST_ROUND:
            begin
                if (rnd_last)
                begin
                    state_next = sha_pkg::ST_FINAL;
                end
            end
            sha_pkg::ST_FINAL:
            begin
                state_next = pend_end_reg ? sha_pkg::ST_EMIT : sha_pkg::ST_LOAD;
            end
            sha_pkg::ST_EMIT:
            begin
                if (!d_full && emit_last)
                begin
                    state_next = sha_pkg::ST_LOAD;
                end
            end
            default:
            begin
                state_next = sha_pkg::ST_LOAD;
            end
        endcase
    end

    // outputs and window control
    always_comb
    begin
        q_pop       = 1'b0;
        d_push      = 1'b0;
        shift_en    = 1'b0;
        shift_in    = w_new;
        load_blk    = 1'b0;
        d_item.word = chain_reg[idx_reg];
        d_item.last = emit_last;
        case (state_reg)
            sha_pkg::ST_LOAD:
            begin
                q_pop    = q_valid;
                shift_en = q_valid;
                shift_in = q_item.word;
                load_blk = q_valid && q_item.blk_last;
            end
            sha_pkg::ST_ROUND:
            begin
                shift_en = 1'b1;
            end
            sha_pkg::ST_FINAL:
            begin
                shift_en = 1'b0;
            end
            sha_pkg::ST_EMIT:
            begin
                d_push = !d_full;
            end
            default:
            begin
                q_pop = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= sha_pkg::ST_LOAD;
            mode_reg     <= sha_pkg::MODE_SHA256;
            pend_end_reg <= 1'b0;
            rnd_reg      <= '0;
            idx_reg      <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            pend_end_reg <= pend_end_next;
            if (cfg_write)
            begin
                mode_reg <= cfg_mode;
            end
            if (state_reg == sha_pkg::ST_ROUND)
            begin
                rnd_reg <= rnd_reg + 1'b1;
            end
            if (d_push)
            begin
                idx_reg <= emit_last ? 3'd0 : idx_reg + 3'd1;
            end
        end
    end

    // chaining values
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < sha_pkg::WORDS; i++)
            begin
                chain_reg[i] <= sha_pkg::IV256[i];
            end
        end
        else if (cfg_write)
        begin
            for (int i = 0; i < sha_pkg::WORDS; i++)
            begin
                chain_reg[i] <= sha_pkg::iv_word(cfg_mode, 3'(i));
            end
        end
        else if (state_reg == sha_pkg::ST_FINAL)
        begin
            for (int i = 0; i < sha_pkg::WORDS; i++)
            begin
                chain_reg[i] <= chain_reg[i] + v_reg[i];
            end
        end
        else if (d_push && emit_last)
        begin
            for (int i = 0; i < sha_pkg::WORDS; i++)
            begin
                chain_reg[i] <= sha_pkg::iv_word(mode_reg, 3'(i));
            end
        end
    end

    // working variables a..h
    always_ff @(posedge clk)
    begin
        if (load_blk)
        begin
            for (int i = 0; i < sha_pkg::WORDS; i++)
            begin
                v_reg[i] <= chain_reg[i];
            end
        end
        else if (state_reg == sha_pkg::ST_ROUND)
        begin
            v_reg[7] <= v_reg[6];
            v_reg[6] <= v_reg[5];
            v_reg[5] <= v_reg[4];
            v_reg[4] <= v_reg[3] + t1;
            v_reg[3] <= v_reg[2];
            v_reg[2] <= v_reg[1];
            v_reg[1] <= v_reg[0];
            v_reg[0] <= t1 + t2;
        end
    end

    // message schedule window, oldest word at the bottom
    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            for (int i = 0; i < sha_pkg::BLK_WORDS - 1; i++)
            begin
                w_reg[i] <= w_reg[i + 1];
            end
            w_reg[sha_pkg::BLK_WORDS - 1] <= shift_in;
        end
    end

    `SHA_ASSERT_IMP(a_rnd_idle, state_reg != sha_pkg::ST_ROUND, rnd_reg == '0, "round counter left running")
    `SHA_ASSERT_NXT(a_rnd_final, state_reg == sha_pkg::ST_ROUND && rnd_last, state_reg == sha_pkg::ST_FINAL, "rounds did not finish")
    `SHA_ASSERT_IMP(a_no_overflow, d_push, !d_full, "digest pushed into full queue")
    `SHA_ASSERT_IMP(a_idx_224, state_reg == sha_pkg::ST_EMIT && mode_reg == sha_pkg::MODE_SHA224, idx_reg != sha_pkg::LAST_IDX_256, "eighth word in sha-224 mode")

endmodule
